### rtl/core/msbbr_pkg.sv
// Shared types and constants for the MSB-first bit reader.
// No dependencies; imported by msbbr_ctrl, msbbr_dp and the top level.
`default_nettype none
package msbbr_pkg;

    localparam int BYTE_BITS = 8;
    localparam int COUNT_W   = 16;            // width of a bit count request
    localparam int SUM_W     = COUNT_W + 1;   // position plus count, no overflow

    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_READ    = 2'd1,
        REQ_SKIP    = 2'd2,
        REQ_RESTART = 2'd3
    } t_req;

    // controller -> datapath
    typedef struct packed {
        logic cap;       // capture the incoming transaction
        logic append;    // store the byte, bump the length
        logic restart;   // clear length and position
        logic skip;      // advance the position
        logic rd_start;  // first store read, set up the group counters
        logic rd_prime;  // latch first byte, read the next one
        logic rd_group;  // emit one output byte, read the next one
        logic emit_err;  // emit the error result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic skip_err;
        logic read_zero;
        logic read_err;
        logic last_group;
    } t_sts;

endpackage
`default_nettype wire

### rtl/core/msbbr_ctrl.sv
// Sequencing state machine for the MSB-first bit reader.
// Depends on msbbr_pkg; drives msbbr_dp through t_cmd, watches t_sts.
`default_nettype none
module msbbr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  msbbr_pkg::t_sts      i_sts,
    output msbbr_pkg::t_cmd      o_cmd
);
    import msbbr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIRST,
        S_GROUP
    } t_state;

    t_state r_state, n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_sts.req)
                    REQ_APPEND:  o_cmd.append  = 1'b1;
                    REQ_RESTART: o_cmd.restart = 1'b1;
                    REQ_SKIP: begin
                        if (i_sts.skip_err) o_cmd.emit_err = 1'b1;
                        else                o_cmd.skip     = 1'b1;
                    end
                    REQ_READ: begin
                        priority if (i_sts.read_zero) begin
                            // zero-bit read: nothing to do
                        end else if (i_sts.read_err) begin
                            o_cmd.emit_err = 1'b1;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = S_FIRST;
                        end
                    end
                    default: ;
                endcase
            end
            S_FIRST: begin
                o_cmd.rd_prime = 1'b1;
                n_state        = S_GROUP;
            end
            S_GROUP: begin
                o_cmd.rd_group = 1'b1;
                if (i_sts.last_group) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### rtl/core/msbbr_dp.sv
// Datapath of the MSB-first bit reader: byte store, length, position, group
// extraction and result registers. Depends on msbbr_pkg; run by msbbr_ctrl.
`default_nettype none
module msbbr_dp #(
    parameter int STORE_BYTES   = 4096,
    parameter int MAX_READ_BITS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic [msbbr_pkg::COUNT_W-1:0] i_bit_count,
    input  msbbr_pkg::t_cmd                    i_cmd,
    output msbbr_pkg::t_sts                    o_sts,
    output logic                               o_strobe,
    output logic [7:0]                         o_out_byte,
    output logic                               o_last,
    output logic                               o_error
);
    import msbbr_pkg::*;

    localparam int LEN_W      = $clog2(STORE_BYTES + 1);
    localparam int AW         = $clog2(STORE_BYTES);
    localparam int STORE_BITS = STORE_BYTES * BYTE_BITS;
    localparam int POS_W      = $clog2(STORE_BITS + 1);
    localparam int CNT_W      = $clog2(MAX_READ_BITS + 1);

    logic [7:0] mem [STORE_BYTES];

    // captured transaction
    t_req               r_req;
    logic [7:0]         r_byte;
    logic [COUNT_W-1:0] r_count;

    // stream state
    logic [LEN_W-1:0] r_len;
    logic [POS_W-1:0] r_bp;

    // read sequencing
    logic [LEN_W-1:0] r_addr;
    logic [2:0]       r_off;
    logic [CNT_W-1:0] r_rem;
    logic [7:0]       r_hi;
    logic [7:0]       r_rd_data;

    logic             r_strobe;
    logic [7:0]       r_out_byte;
    logic             r_last;
    logic             r_error;

    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] rd_sel;
    logic             rd_en;
    logic [15:0]      win;
    logic [3:0]       grp;
    logic [7:0]       grp_byte;
    logic             full;

    assign sum  = SUM_W'(r_bp) + SUM_W'(r_count);
    assign idx  = LEN_W'(r_bp >> 3);
    assign full = (r_len == LEN_W'(STORE_BYTES));

    assign o_sts.req        = r_req;
    assign o_sts.skip_err   = (sum > SUM_W'(STORE_BITS));
    assign o_sts.read_zero  = (r_count == '0);
    assign o_sts.read_err   = (r_count > COUNT_W'(MAX_READ_BITS))
                           || (sum > SUM_W'({r_len, 3'b000}));
    assign o_sts.last_group = (r_rem <= CNT_W'(BYTE_BITS));

    // the byte after the last store entry is never needed; skip the read
    assign rd_sel = i_cmd.rd_start ? idx : r_addr;
    assign rd_en  = (i_cmd.rd_start || i_cmd.rd_prime || i_cmd.rd_group)
                 && (rd_sel < LEN_W'(STORE_BYTES));

    // window of two stream bytes, aligned to the group's first bit
    assign win      = {r_hi, r_rd_data} << r_off;
    assign grp      = o_sts.last_group ? r_rem[3:0] : 4'd8;
    assign grp_byte = win[15:8] >> (4'd8 - grp);

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            mem[r_len[AW-1:0]] <= r_byte;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_sel[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req   <= t_req'(i_req_type);
            r_byte  <= i_data_byte;
            r_count <= i_bit_count;
        end
        if (i_cmd.rd_start) begin
            r_addr <= idx + LEN_W'(1);
            r_off  <= r_bp[2:0];
            r_rem  <= CNT_W'(r_count);
        end
        if (i_cmd.rd_prime) begin
            r_hi   <= r_rd_data;
            r_addr <= r_addr + LEN_W'(1);
        end
        if (i_cmd.rd_group) begin
            r_hi   <= r_rd_data;
            r_addr <= r_addr + LEN_W'(1);
            r_rem  <= r_rem - CNT_W'(BYTE_BITS);
        end
        if (i_cmd.rd_group) begin
            r_out_byte <= grp_byte;
            r_last     <= o_sts.last_group;
            r_error    <= 1'b0;
        end else if (i_cmd.emit_err) begin
            r_out_byte <= '0;
            r_last     <= 1'b1;
            r_error    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_bp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.rd_group || i_cmd.emit_err;
            if (i_cmd.restart) begin
                r_len <= '0;
                r_bp  <= '0;
            end
            if (i_cmd.append && !full) begin
                r_len <= r_len + LEN_W'(1);
            end
            if (i_cmd.skip || i_cmd.rd_start) begin
                r_bp <= sum[POS_W-1:0];
            end
        end
    end

    assign o_strobe   = r_strobe;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_last;
    assign o_error    = r_error;

endmodule
`default_nettype wire

### rtl/core/msb_first_bit_reader_unit.sv
// Top level of the MSB-first bit reader: controller plus datapath.
// Depends on msbbr_pkg, msbbr_ctrl and msbbr_dp.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  request   | start in, busy out     | i_req_type, i_data_byte, i_bit_count
//  result    | o_strobe out           | o_out_byte, o_last, o_error
//
// A transaction is taken when start is high and busy low. A read of N bits gives
// ceil(N/8) output bytes, one output byte per cycle once the first store byte is
// in, set by the single read port of the store. Errors show in the cycle after
// the decode cycle. Synchronous active-low reset clears length, position and
// control; the store itself is not cleared. Results are shown for one cycle and
// cannot be stalled.
`default_nettype none
module msb_first_bit_reader_unit #(
    parameter int STORE_BYTES   = 4096,
    parameter int MAX_READ_BITS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic [msbbr_pkg::COUNT_W-1:0] i_bit_count,
    output logic                               o_strobe,
    output logic [7:0]                         o_out_byte,
    output logic                               o_last,
    output logic                               o_error
);
    import msbbr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    msbbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    msbbr_dp #(
        .STORE_BYTES   (STORE_BYTES),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_bit_count (i_bit_count),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_strobe    (o_strobe),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule
`default_nettype wire

### tb/tb_msb_first_bit_reader_unit.sv
// Self-checking testbench for msb_first_bit_reader_unit: directed, random and store-end traffic.
// Depends on msbbr_pkg and the RTL top level. A built-in bit-field predictor checks every
// result byte against its expectation.
module tb_msb_first_bit_reader_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import msbbr_pkg::*;

    localparam int STORE_BYTES   = 4096;
    localparam int MAX_READ_BITS = 64;
    localparam int STORE_BITS    = STORE_BYTES * BYTE_BITS;
    localparam int RANDOM_ITEMS  = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 24;

    typedef struct packed {
        t_req         req;
        logic [7:0]   data;
        logic [15:0]  count;
    } t_request;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       err;
    } t_field_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [7:0]  i_data_byte;
    logic [15:0] i_bit_count;
    logic        o_strobe;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_error;

    msb_first_bit_reader_unit #(
        .STORE_BYTES   (STORE_BYTES),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_bit_count (i_bit_count),
        .o_strobe    (o_strobe),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // pending requests, expected result bytes
    t_request    pending_reqs[$];
    t_field_byte expected_bytes[$];

    // predictor state
    logic [7:0]  bits_mem[STORE_BYTES];
    int          bits_len;
    int          bits_pos;

    // generator-side view of length and position, used only to aim reads
    int          gen_len;
    int          gen_pos;
    int          random_count;

    bit          rst_released;
    bit          taken;
    int          burst_left;
    int          gap_left;
    int          quiet_cycles;
    int          fails;
    int          n_sent;
    int          n_checked;
    int          n_err_results;
    int          n_reads;

    task automatic queue_item(input t_req req, input logic [7:0] data, input int count);
        t_request r;
        r.req   = req;
        r.data  = data;
        r.count = count[15:0];
        pending_reqs.push_back(r);
        if (!(req == REQ_READ && count == 0))
            random_count++;
        case (req)
            REQ_APPEND:  if (gen_len < STORE_BYTES) gen_len++;
            REQ_RESTART: begin
                gen_len = 0;
                gen_pos = 0;
            end
            REQ_SKIP:    if (gen_pos + count <= STORE_BITS) gen_pos += count;
            default:     if (count > 0 && count <= MAX_READ_BITS && gen_pos + count <= gen_len * 8)
                             gen_pos += count;
        endcase
    endtask

    task automatic push_refusal();
        t_field_byte e;
        e.value = 8'h00;
        e.last  = 1'b1;
        e.err   = 1'b1;
        expected_bytes.push_back(e);
    endtask

    // works out the result bytes of one accepted transaction
    task automatic extract_fields(input t_request r);
        int          cnt;
        int          n;
        logic [7:0]  acc;
        t_field_byte e;
        cnt = int'(r.count);
        case (r.req)
            REQ_APPEND: begin
                if (bits_len < STORE_BYTES) begin
                    bits_mem[bits_len] = r.data;
                    bits_len++;
                end
            end
            REQ_RESTART: begin
                bits_len = 0;
                bits_pos = 0;
            end
            REQ_SKIP: begin
                if (bits_pos + cnt > STORE_BITS)
                    push_refusal();
                else
                    bits_pos += cnt;
            end
            default: begin
                n_reads++;
                if (cnt == 0) begin
                    // nothing to do
                end else if (cnt > MAX_READ_BITS || bits_pos + cnt > bits_len * 8) begin
                    push_refusal();
                end else begin
                    acc = 8'h00;
                    for (n = 1; n <= cnt; n++) begin
                        acc = {acc[6:0], bits_mem[bits_pos >> 3][7 - (bits_pos & 7)]};
                        bits_pos++;
                        if (n % 8 == 0 || n == cnt) begin
                            e.value = acc;
                            e.last  = (n == cnt);
                            e.err   = 1'b0;
                            expected_bytes.push_back(e);
                            acc = 8'h00;
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic build_random_traffic();
        int pick;
        int avail;
        int k;
        int hi;
        while (random_count < RANDOM_ITEMS) begin
            pick  = $urandom_range(0, 99);
            avail = gen_len * 8 - gen_pos;
            if (pick < 4) begin
                queue_item(REQ_RESTART, 8'($urandom), $urandom_range(0, 32768));
            end else if (pick < 34 || (pick < 72 && avail <= 0)) begin
                hi = $urandom_range(1, 6);
                for (k = 0; k < hi; k++)
                    queue_item(REQ_APPEND, 8'($urandom), $urandom_range(0, 32768));
            end else if (pick < 72) begin
                hi = (avail < MAX_READ_BITS) ? avail : MAX_READ_BITS;
                if ($urandom_range(0, 5) == 0)
                    queue_item(REQ_READ, 8'($urandom), hi);
                else
                    queue_item(REQ_READ, 8'($urandom), $urandom_range(1, hi));
            end else if (pick < 84) begin
                // small skips, some of them past the loaded bytes
                queue_item(REQ_SKIP, 8'($urandom), $urandom_range(0, 24));
            end else if (pick < 92) begin
                queue_item(REQ_READ, 8'($urandom), $urandom_range(0, 32768));
            end else if (pick < 96) begin
                queue_item(REQ_SKIP, 8'($urandom), 32768 - $urandom_range(0, 3));
            end else begin
                queue_item(t_req'($urandom_range(0, 3)), 8'($urandom),
                           $urandom_range(0, 32768));
            end
        end
    endtask

    initial begin
        int k;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = REQ_APPEND;
        i_data_byte = 8'h00;
        i_bit_count = 16'h0000;
        bits_len    = 0;
        bits_pos    = 0;
        gen_len     = 0;
        gen_pos     = 0;
        for (k = 0; k < STORE_BYTES; k++)
            bits_mem[k] = 8'h00;

        // directed: empty reads, edge bytes, group boundaries, width limit, store end
        queue_item(REQ_READ,    8'h00, 8);
        queue_item(REQ_READ,    8'hFF, 0);
        queue_item(REQ_APPEND,  8'h00, 0);
        queue_item(REQ_APPEND,  8'hFF, 0);
        queue_item(REQ_APPEND,  8'hA5, 0);
        queue_item(REQ_APPEND,  8'h5A, 0);
        queue_item(REQ_APPEND,  8'h80, 0);
        queue_item(REQ_APPEND,  8'h01, 0);
        queue_item(REQ_APPEND,  8'h3C, 0);
        queue_item(REQ_APPEND,  8'hC3, 0);
        queue_item(REQ_APPEND,  8'h96, 0);
        queue_item(REQ_READ,    8'h00, 1);
        queue_item(REQ_READ,    8'h00, 7);
        queue_item(REQ_READ,    8'h00, 13);
        queue_item(REQ_SKIP,    8'h00, 3);
        queue_item(REQ_READ,    8'h00, MAX_READ_BITS + 1);
        queue_item(REQ_READ,    8'h00, 32768);
        queue_item(REQ_SKIP,    8'h00, 0);
        queue_item(REQ_READ,    8'h00, 40);
        queue_item(REQ_READ,    8'h00, 9);
        queue_item(REQ_RESTART, 8'h00, 0);
        queue_item(REQ_READ,    8'h00, 1);
        queue_item(REQ_SKIP,    8'h00, 32768);
        queue_item(REQ_SKIP,    8'h00, 1);
        queue_item(REQ_RESTART, 8'h00, 0);

        build_random_traffic();

        // walk the position up to the far end of the store and probe around it
        queue_item(REQ_RESTART, 8'h00, 0);
        queue_item(REQ_SKIP,    8'h00, STORE_BITS - 2 * MAX_READ_BITS);
        queue_item(REQ_READ,    8'h00, MAX_READ_BITS);
        queue_item(REQ_SKIP,    8'h00, 2 * MAX_READ_BITS);
        queue_item(REQ_SKIP,    8'h00, 1);
        queue_item(REQ_SKIP,    8'h00, 0);
        queue_item(REQ_READ,    8'h00, 1);
        queue_item(REQ_RESTART, 8'h00, 0);
        queue_item(REQ_READ,    8'h00, 8);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n      = 1'b1;
        rst_released = 1'b1;

        while (pending_reqs.size() != 0 || start || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            $error("%0d expected result bytes never arrived", expected_bytes.size());
            fails++;
        end

        $display("Sent %0d transactions (%0d reads), incl. skips up to the store end.",
                 n_sent, n_reads);
        $display("Checked %0d result bytes, %0d of them refusals; %0d failures.",
                 n_checked, n_err_results, fails);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // driver: bursts of back-to-back requests separated by random gaps
    always @(negedge i_clk) begin
        t_request cur;
        if (rst_released && !(start && !taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur = pending_reqs.pop_front();
                start       <= 1'b1;
                i_req_type  <= cur.req;
                i_data_byte <= cur.data;
                i_bit_count <= cur.count;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(0, 12);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(8, 20);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // request acceptance feeds the predictor
    always @(posedge i_clk) begin
        t_request r;
        if (i_rst_n && start && !busy) begin
            r.req   = t_req'(i_req_type);
            r.data  = i_data_byte;
            r.count = i_bit_count;
            extract_fields(r);
            n_sent++;
            taken <= 1'b1;
        end else begin
            taken <= 1'b0;
        end
    end

    // monitor: every strobed byte against the oldest expectation
    always @(posedge i_clk) begin
        t_field_byte e;
        if (i_rst_n && o_strobe) begin
            if (expected_bytes.size() == 0) begin
                $error("result with nothing expected: out_byte %0h last %0b error %0b",
                       o_out_byte, o_last, o_error);
                fails++;
            end else begin
                e = expected_bytes.pop_front();
                n_checked++;
                if (e.err)
                    n_err_results++;
                if (o_out_byte !== e.value) begin
                    $error("out_byte: expected %0h, got %0h", e.value, o_out_byte);
                    fails++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0b, got %0b", e.last, o_last);
                    fails++;
                end
                if (o_error !== e.err) begin
                    $error("error: expected %0b, got %0b", e.err, o_error);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (rst_released) begin
            if ((start && !busy) || o_strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

### files.f
rtl/core/msbbr_pkg.sv
rtl/core/msbbr_ctrl.sv
rtl/core/msbbr_dp.sv
rtl/core/msb_first_bit_reader_unit.sv
tb/tb_msb_first_bit_reader_unit.sv
